// File: rtl/core/npcr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// npcr_pkg: shared types and constants for the nearest palette color search
// Beat formats for the input and result channels, the distance beat that
// travels from the distance pipeline to the minimum tracker, and the
// redmean weighting constants.
// ----------------------------------------------------------------------------
package npcr_pkg;

    localparam int unsigned RGB_W  = 24;
    localparam int unsigned CHAN_W = 8;
    localparam int unsigned CODE_W = 8;
    localparam int unsigned DIST_W = 20;

    // Redmean weights: red uses 512 + mean, blue uses 767 - mean.
    localparam logic [9:0] RED_BASE  = 10'd512;
    localparam logic [9:0] BLUE_BASE = 10'd767;

    // Red and blue products are scaled down by 256, green is scaled up by 4.
    localparam int unsigned TERM_SHIFT  = 8;
    localparam int unsigned GREEN_SHIFT = 2;

    typedef struct packed {
        logic [RGB_W-1:0]  target_rgb;
        logic [RGB_W-1:0]  candidate_rgb;
        logic [CODE_W-1:0] candidate_code;
        logic              first_entry;
        logic              last_entry;
    } in_beat_t;

    typedef struct packed {
        logic [CODE_W-1:0] nearest_code;
        logic [DIST_W-1:0] nearest_distance_sq;
    } out_beat_t;

    // Sideband that rides along the distance pipeline.
    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic              first;
        logic              last;
    } tag_t;

    // One classified entry, queued between the front and the back.
    typedef struct packed {
        logic [DIST_W-1:0] distance;
        tag_t              tag;
    } dist_beat_t;

endpackage

// File: rtl/core/nearest_palette_color_redmean.sv
`timescale 1ns / 1ps
// Path: a last-entry beat fills the four distance stages, is written into the
// queue and then loads the result register, when nothing stalls.
// Throughput: one palette entry per cycle while credits remain, set by the queue
// credit count and the combinational compare of the running minimum.
// Reset: rst_n clears pipeline valids, queue, credits, minimum (distance 0, code 0).
// ----------------------------------------------------------------------------
// nearest_palette_color_redmean: nearest palette entry by redmean distance
// Front: distance pipeline. Back: running minimum with a result register.
// A credit-tracked queue between them lets each side stall on its own.
// ----------------------------------------------------------------------------
module nearest_palette_color_redmean #(
    parameter int unsigned QUEUE_DEPTH = 8
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_ready,
    input  npcr_pkg::in_beat_t  item,
    output logic                result_valid,
    input  logic                result_ready,
    output npcr_pkg::out_beat_t result
);
    import npcr_pkg::*;

    localparam int unsigned CRED_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CRED_W-1:0] MAX_CREDIT = CRED_W'(QUEUE_DEPTH);

    logic              accept;
    logic              dist_valid;
    dist_beat_t        dist_beat;
    logic              q_valid;
    dist_beat_t        q_beat;
    logic              q_pop;
    logic [CRED_W-1:0] inflight_reg, inflight_next;

    // Beats in the pipeline plus beats in the queue never exceed its depth.
    assign item_ready = (inflight_reg < MAX_CREDIT);
    assign accept     = item_valid && item_ready;

    always_comb
    begin
        inflight_next = inflight_reg;
        if (accept && !q_pop)
        begin
            inflight_next = inflight_reg + 1'b1;
        end
        else if (q_pop && !accept)
        begin
            inflight_next = inflight_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inflight_reg <= '0;
        end
        else
        begin
            inflight_reg <= inflight_next;
        end
    end

    npcr_dist u_dist (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (accept),
        .in_beat   (item),
        .out_valid (dist_valid),
        .out_beat  (dist_beat)
    );

    npcr_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (dist_valid),
        .push_beat (dist_beat),
        .pop       (q_pop),
        .not_empty (q_valid),
        .head_beat (q_beat)
    );

    npcr_best u_best (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .q_beat       (q_beat),
        .q_pop        (q_pop),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

`ifndef SYNTH
    a_credit_bound: assert property (@(posedge clk) disable iff (!rst_n)
        inflight_reg <= MAX_CREDIT)
        else $error("npcr: credit count exceeds queue depth");

    a_pop_has_credit: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> (inflight_reg != '0))
        else $error("npcr: queue pop without an outstanding beat");

    a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (inflight_reg == '0) |-> (!q_valid && !dist_valid))
        else $error("npcr: beat present with no credit taken");
`endif

endmodule

// File: rtl/core/npcr_dist.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// npcr_dist: redmean distance pipeline
// Four register stages: channel differences and red mean, squares and
// weights, weighted products, then the scaled sum. It never stalls; the
// caller only issues beats for which the queue has room.
// ----------------------------------------------------------------------------
module npcr_dist (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  npcr_pkg::in_beat_t  in_beat,
    output logic                out_valid,
    output npcr_pkg::dist_beat_t out_beat
);
    import npcr_pkg::*;

    // Stage 1 registers.
    logic              s1_valid_reg;
    logic [CHAN_W-1:0] s1_mean_reg;
    logic [CHAN_W-1:0] s1_dr_reg;
    logic [CHAN_W-1:0] s1_dg_reg;
    logic [CHAN_W-1:0] s1_db_reg;
    tag_t              s1_tag_reg;

    // Stage 2 registers.
    logic              s2_valid_reg;
    logic [15:0]       s2_dr_sq_reg;
    logic [15:0]       s2_dg_sq_reg;
    logic [15:0]       s2_db_sq_reg;
    logic [9:0]        s2_red_wt_reg;
    logic [9:0]        s2_blue_wt_reg;
    tag_t              s2_tag_reg;

    // Stage 3 registers.
    logic              s3_valid_reg;
    logic [25:0]       s3_red_prod_reg;
    logic [25:0]       s3_blue_prod_reg;
    logic [17:0]       s3_green_term_reg;
    tag_t              s3_tag_reg;

    // Stage 4 registers.
    logic              s4_valid_reg;
    dist_beat_t        s4_beat_reg;

    logic [CHAN_W-1:0] r_t, g_t, b_t, r_c, g_c, b_c;
    logic [CHAN_W-1:0] mean_next, dr_next, dg_next, db_next;
    logic [17:0]       red_scaled, blue_scaled;

    // Split the packed colors into channels.
    assign r_t = in_beat.target_rgb[23:16];
    assign g_t = in_beat.target_rgb[15:8];
    assign b_t = in_beat.target_rgb[7:0];
    assign r_c = in_beat.candidate_rgb[23:16];
    assign g_c = in_beat.candidate_rgb[15:8];
    assign b_c = in_beat.candidate_rgb[7:0];

    // Red mean and absolute channel differences.
    always_comb
    begin
        mean_next = 8'((9'(r_t) + 9'(r_c)) >> 1);
        dr_next   = (r_t > r_c) ? (r_t - r_c) : (r_c - r_t);
        dg_next   = (g_t > g_c) ? (g_t - g_c) : (g_c - g_t);
        db_next   = (b_t > b_c) ? (b_t - b_c) : (b_c - b_t);
    end

    // Scaled red and blue terms; both fit in 18 bits after the shift.
    assign red_scaled  = 18'(s3_red_prod_reg >> TERM_SHIFT);
    assign blue_scaled = 18'(s3_blue_prod_reg >> TERM_SHIFT);

    // Stage valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        s1_mean_reg      <= mean_next;
        s1_dr_reg        <= dr_next;
        s1_dg_reg        <= dg_next;
        s1_db_reg        <= db_next;
        s1_tag_reg.code  <= in_beat.candidate_code;
        s1_tag_reg.first <= in_beat.first_entry;
        s1_tag_reg.last  <= in_beat.last_entry;

        s2_dr_sq_reg   <= 16'(s1_dr_reg) * 16'(s1_dr_reg);
        s2_dg_sq_reg   <= 16'(s1_dg_reg) * 16'(s1_dg_reg);
        s2_db_sq_reg   <= 16'(s1_db_reg) * 16'(s1_db_reg);
        s2_red_wt_reg  <= RED_BASE + 10'(s1_mean_reg);
        s2_blue_wt_reg <= BLUE_BASE - 10'(s1_mean_reg);
        s2_tag_reg     <= s1_tag_reg;

        s3_red_prod_reg   <= 26'(s2_red_wt_reg) * 26'(s2_dr_sq_reg);
        s3_blue_prod_reg  <= 26'(s2_blue_wt_reg) * 26'(s2_db_sq_reg);
        s3_green_term_reg <= 18'(s2_dg_sq_reg) << GREEN_SHIFT;
        s3_tag_reg        <= s2_tag_reg;

        s4_beat_reg.distance <= 20'(red_scaled) + 20'(blue_scaled)
                                + 20'(s3_green_term_reg);
        s4_beat_reg.tag      <= s3_tag_reg;
    end

    assign out_valid = s4_valid_reg;
    assign out_beat  = s4_beat_reg;

endmodule

// File: rtl/core/npcr_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// npcr_fifo: queue of distance beats
// Register-based circular buffer between the distance pipeline and the
// minimum tracker. The head entry is presented without a read delay.
// ----------------------------------------------------------------------------
module npcr_fifo #(
    parameter int unsigned DEPTH = 8
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  npcr_pkg::dist_beat_t push_beat,
    input  logic                 pop,
    output logic                 not_empty,
    output npcr_pkg::dist_beat_t head_beat
);
    import npcr_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    dist_beat_t       entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    // Pointer and fill count updates.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_beat;
        end
    end

    assign not_empty = (count_reg != '0);
    assign head_beat = entry_reg[rd_ptr_reg];

`ifndef SYNTH
    // The caller's credit scheme must keep writes out of a full queue.
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == FULL_CNT) |-> (!push || pop))
        else $error("npcr_fifo: push into full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> not_empty)
        else $error("npcr_fifo: pop from empty queue");

    // Pointers meet when the queue is empty or full.
    a_ptr_count: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0 || count_reg == FULL_CNT) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("npcr_fifo: pointers disagree with fill count");
`endif

endmodule

// File: rtl/core/npcr_best.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// npcr_best: running minimum and result register
// Pops distance beats from the queue, keeps the least distance of the run
// and its code, and loads the result register on the last entry of a run.
// ----------------------------------------------------------------------------
module npcr_best (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 q_valid,
    input  npcr_pkg::dist_beat_t q_beat,
    output logic                 q_pop,
    output logic                 result_valid,
    input  logic                 result_ready,
    output npcr_pkg::out_beat_t  result
);
    import npcr_pkg::*;

    logic [DIST_W-1:0] best_dist_reg, best_dist_next;
    logic [CODE_W-1:0] best_code_reg, best_code_next;
    logic              res_valid_reg, res_valid_next;
    out_beat_t         res_reg, res_next;
    logic              take;

    // A last entry may only leave the queue when the result slot is free.
    assign q_pop = q_valid
                   && (!q_beat.tag.last || !res_valid_reg || result_ready);

    // First entry of a run always wins; a tie keeps the earlier entry.
    assign take = q_beat.tag.first || (q_beat.distance < best_dist_reg);

    always_comb
    begin
        best_dist_next = best_dist_reg;
        best_code_next = best_code_reg;
        res_next       = res_reg;
        res_valid_next = res_valid_reg && !result_ready;
        if (q_pop)
        begin
            if (take)
            begin
                best_dist_next = q_beat.distance;
                best_code_next = q_beat.tag.code;
            end
            if (q_beat.tag.last)
            begin
                res_valid_next               = 1'b1;
                res_next.nearest_code        = best_code_next;
                res_next.nearest_distance_sq = best_dist_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            best_dist_reg <= '0;
            best_code_reg <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            best_dist_reg <= best_dist_next;
            best_code_reg <= best_code_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign result_valid = res_valid_reg;
    assign result       = res_reg;

`ifndef SYNTH
    // The held minimum never grows within a run.
    a_min_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        (q_pop && !q_beat.tag.first) |=> (best_dist_reg <= $past(best_dist_reg)))
        else $error("npcr_best: running minimum increased");

    // A result reports the minimum as it stands after its run.
    a_result_matches: assert property (@(posedge clk) disable iff (!rst_n)
        (q_pop && q_beat.tag.last) |=>
            (result.nearest_distance_sq == best_dist_reg
             && result.nearest_code == best_code_reg))
        else $error("npcr_best: result differs from held minimum");

    // A pending result is never overwritten.
    a_no_clobber: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && !result_ready) |-> !(q_pop && q_beat.tag.last))
        else $error("npcr_best: pending result overwritten");
`endif

endmodule

// File: test/nearest_palette_color_redmean_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nearest_palette_color_redmean_checker: scoreboard for the palette search
// Watches both channels of the block. Every accepted entry beat updates a
// local running minimum of the redmean distance. Every last-entry beat queues
// the nearest code and distance that the block must return. Result beats are
// compared field by field against the oldest queued entry.
// ----------------------------------------------------------------------------
module nearest_palette_color_redmean_checker (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    input  logic                item_ready,
    input  npcr_pkg::in_beat_t  item,
    input  logic                result_valid,
    input  logic                result_ready,
    input  npcr_pkg::out_beat_t result,
    output int                  fail_count,
    output int                  pending
);
    import npcr_pkg::*;

    // Running minimum of the current search run, as the block should hold it.
    logic [DIST_W-1:0] min_distance;
    logic [CODE_W-1:0] min_code;
    out_beat_t         nearest_q[$];
    int                mismatches;

    // Redmean weighted squared distance, without the root.
    function automatic logic [DIST_W-1:0] redmean_dist_sq(
        input logic [RGB_W-1:0] tgt,
        input logic [RGB_W-1:0] cand
    );
        int unsigned rt;
        int unsigned rc;
        int unsigned gt;
        int unsigned gc;
        int unsigned bt;
        int unsigned bc;
        int unsigned mean;
        int unsigned dr;
        int unsigned dg;
        int unsigned db;
        int unsigned red_term;
        int unsigned green_term;
        int unsigned blue_term;
        rt = 32'(tgt[23:16]);
        rc = 32'(cand[23:16]);
        gt = 32'(tgt[15:8]);
        gc = 32'(cand[15:8]);
        bt = 32'(tgt[7:0]);
        bc = 32'(cand[7:0]);
        mean = (rt + rc) >> 1;
        dr = (rt > rc) ? rt - rc : rc - rt;
        dg = (gt > gc) ? gt - gc : gc - gt;
        db = (bt > bc) ? bt - bc : bc - bt;
        red_term   = ((32'(RED_BASE) + mean) * dr * dr) >> TERM_SHIFT;
        green_term = (dg * dg) << GREEN_SHIFT;
        blue_term  = ((32'(BLUE_BASE) - mean) * db * db) >> TERM_SHIFT;
        return DIST_W'(red_term + green_term + blue_term);
    endfunction

    // Track the minimum on entry beats and check result beats in order.
    always @(posedge clk or negedge rst_n)
    begin : track_and_compare
        out_beat_t         want;
        logic [DIST_W-1:0] entry_dist;
        if (!rst_n)
        begin
            min_distance = '0;
            min_code     = '0;
            nearest_q.delete();
            mismatches   = 0;
            fail_count  <= 0;
            pending     <= 0;
        end
        else
        begin
            // Results come out only after their last entry has passed the distance stages
            // and the queue, so the result beat of this edge never belongs to this edge's entry.
            if (result_valid && result_ready)
            begin
                if (nearest_q.size() == 0)
                begin
                    $error("unexpected result beat: nearest_code %0d nearest_distance_sq %0d",
                           result.nearest_code, result.nearest_distance_sq);
                    mismatches++;
                end
                else
                begin
                    want = nearest_q.pop_front();
                    if (result.nearest_code !== want.nearest_code)
                    begin
                        $error("nearest_code: expected %0d, actual %0d",
                               want.nearest_code, result.nearest_code);
                        mismatches++;
                    end
                    if (result.nearest_distance_sq !== want.nearest_distance_sq)
                    begin
                        $error("nearest_distance_sq: expected %0d, actual %0d",
                               want.nearest_distance_sq, result.nearest_distance_sq);
                        mismatches++;
                    end
                end
            end

            // A first entry restarts the search; a tie keeps the earlier entry.
            if (item_valid && item_ready)
            begin
                entry_dist = redmean_dist_sq(item.target_rgb, item.candidate_rgb);
                if (item.first_entry || entry_dist < min_distance)
                begin
                    min_distance = entry_dist;
                    min_code     = item.candidate_code;
                end
                if (item.last_entry)
                begin
                    want.nearest_code        = min_code;
                    want.nearest_distance_sq = min_distance;
                    nearest_q.push_back(want);
                end
            end

            fail_count <= mismatches;
            pending    <= nearest_q.size();
        end
    end

endmodule

// File: test/nearest_palette_color_redmean_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nearest_palette_color_redmean_tb: stimulus and verdict for the palette search
// Sends a short directed set of palette runs, then random runs in three
// phases of sender and receiver idling. A separate checker predicts every
// result beat. One long receiver hold-off fills the block, and sender pauses,
// midway and at the end, let every outstanding result drain.
// ----------------------------------------------------------------------------
module nearest_palette_color_redmean_tb;
    import npcr_pkg::*;

    localparam int unsigned WATCHDOG_LIMIT = 5000;
    localparam int unsigned HOLD_CYCLES    = 300;
    localparam int unsigned TAIL_CYCLES    = 20;

    logic      clk;
    logic      rst_n;
    logic      item_valid;
    logic      item_ready;
    in_beat_t  item;
    logic      result_valid;
    logic      result_ready;
    out_beat_t result;

    int fail_count;
    int pending;
    int tx_idle_pct;
    int rx_idle_pct;
    int hold_reqs;
    int beats_sent;
    int stuck_cycles = 0;

    nearest_palette_color_redmean dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    nearest_palette_color_redmean_checker scoreboard (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .fail_count   (fail_count),
        .pending      (pending)
    );

    initial clk = 1'b0;
    always #4 clk = ~clk;

    // Receiver: random stalls, or one long hold-off counted here.
    initial
    begin : result_sink
        int hold_left;
        int hold_seen;
        hold_left    = 0;
        hold_seen    = 0;
        result_ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_reqs != hold_seen)
            begin
                hold_left = HOLD_CYCLES;
                hold_seen = hold_reqs;
            end
            if (hold_left > 0)
            begin
                result_ready <= 1'b0;
                hold_left--;
            end
            else
            begin
                result_ready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    // Watchdog: too many cycles without any beat on either channel.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((item_valid && item_ready) || (result_valid && result_ready))
            begin
                stuck_cycles <= 0;
            end
            else if (stuck_cycles >= WATCHDOG_LIMIT)
            begin
                $display("CHECK FAILED");
                $finish;
            end
            else
            begin
                stuck_cycles <= stuck_cycles + 1;
            end
        end
    end

    function automatic in_beat_t make_beat(
        input logic [RGB_W-1:0]  tgt,
        input logic [RGB_W-1:0]  cand,
        input logic [CODE_W-1:0] code,
        input logic              first,
        input logic              last
    );
        in_beat_t beat;
        beat.target_rgb     = tgt;
        beat.candidate_rgb  = cand;
        beat.candidate_code = code;
        beat.first_entry    = first;
        beat.last_entry     = last;
        return beat;
    endfunction

    // Mostly random colors, with black and white now and then.
    function automatic logic [RGB_W-1:0] random_color();
        case ($urandom_range(9))
            0:       return 24'h000000;
            1:       return 24'hFFFFFF;
            default: return RGB_W'($urandom);
        endcase
    endfunction

    // Candidates close to the target make replacements and ties common.
    function automatic logic [RGB_W-1:0] pick_candidate(input logic [RGB_W-1:0] tgt);
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        r = tgt[23:16] + 8'($urandom_range(8)) - 8'd4;
        g = tgt[15:8] + 8'($urandom_range(8)) - 8'd4;
        b = tgt[7:0] + 8'($urandom_range(8)) - 8'd4;
        case ($urandom_range(9))
            0, 1, 2, 3: return {r, g, b};
            4:          return tgt;
            5:          return random_color();
            default:    return RGB_W'($urandom);
        endcase
    endfunction

    // Offer one beat, idling first at the sender's rate.
    task automatic send_beat(input in_beat_t beat);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item       <= beat;
        item_valid <= 1'b1;
        @(posedge clk);
        while (!item_ready)
            @(posedge clk);
        beats_sent++;
    endtask

    // One search run; a broken run may flip its marks or drift its target.
    task automatic send_run(input int len, input bit broken);
        logic [RGB_W-1:0] tgt;
        logic             first;
        logic             last;
        int               i;
        tgt = random_color();
        for (i = 0; i < len; i++)
        begin
            first = (i == 0);
            last  = (i == len - 1);
            if (broken)
            begin
                if ($urandom_range(3) == 0)
                    first = ~first;
                if ($urandom_range(3) == 0)
                    last = ~last;
                if ($urandom_range(3) == 0)
                    tgt = RGB_W'($urandom);
            end
            send_beat(make_beat(tgt, pick_candidate(tgt), CODE_W'($urandom), first, last));
        end
    endtask

    // Random traffic: mostly well-formed runs, some noise and broken runs.
    task automatic random_phase(input int count);
        int start;
        start = beats_sent;
        while (beats_sent - start < count)
        begin
            case ($urandom_range(9))
                0:
                    send_beat(make_beat(RGB_W'($urandom), RGB_W'($urandom),
                                        CODE_W'($urandom), 1'($urandom), 1'($urandom)));
                1:
                    send_run($urandom_range(1, 6), 1'b1);
                default:
                    send_run($urandom_range(1, 8), 1'b0);
            endcase
        end
    endtask

    // Stop offering beats until every predicted result has arrived.
    task automatic drain_results();
        item_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    initial
    begin : stimulus
        int i;
        rst_n       = 1'b0;
        item_valid  = 1'b0;
        item        = '0;
        hold_reqs   = 0;
        beats_sent  = 0;
        tx_idle_pct = 9;
        rx_idle_pct = 74;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // No start mark right after reset: the cleared minimum of zero holds.
        send_beat(make_beat(24'h000000, 24'hFFFFFF, 8'hAA, 1'b0, 1'b1));
        // Single-entry runs at the color extremes and at zero distance.
        send_beat(make_beat(24'h000000, 24'hFFFFFF, 8'hFF, 1'b1, 1'b1));
        send_beat(make_beat(24'hFFFFFF, 24'h000000, 8'h01, 1'b1, 1'b1));
        send_beat(make_beat(24'h123456, 24'h123456, 8'h55, 1'b1, 1'b1));
        // A tie keeps the earlier entry, then an exact match wins.
        send_beat(make_beat(24'h808080, 24'h818080, 8'h10, 1'b1, 1'b0));
        send_beat(make_beat(24'h808080, 24'h7F8080, 8'h11, 1'b0, 1'b0));
        send_beat(make_beat(24'h808080, 24'h808180, 8'h12, 1'b0, 1'b0));
        send_beat(make_beat(24'h808080, 24'h808080, 8'h13, 1'b0, 1'b1));
        // Entries after the run ended keep comparing against the held minimum.
        send_beat(make_beat(24'h808080, 24'h000000, 8'h20, 1'b0, 1'b0));
        send_beat(make_beat(24'h808080, 24'h808080, 8'h21, 1'b0, 1'b1));
        // Target changes inside a run, one channel at full swing each.
        send_beat(make_beat(24'hFF0000, 24'h000000, 8'h30, 1'b1, 1'b0));
        send_beat(make_beat(24'h00FF00, 24'h000000, 8'h31, 1'b0, 1'b0));
        send_beat(make_beat(24'h0000FF, 24'h000000, 8'h32, 1'b0, 1'b1));
        send_beat(make_beat(24'h000000, 24'h0000FF, 8'h40, 1'b1, 1'b0));
        send_beat(make_beat(24'h000000, 24'h00FF00, 8'h41, 1'b0, 1'b0));
        send_beat(make_beat(24'h000000, 24'hFF0000, 8'h42, 1'b0, 1'b1));
        send_beat(make_beat(24'hFFFFFF, 24'hFFFF00, 8'h50, 1'b1, 1'b1));
        send_beat(make_beat(24'hAAAAAA, 24'h555555, 8'h00, 1'b1, 1'b1));
        send_beat(make_beat(24'h55AA55, 24'hAA55AA, 8'hFF, 1'b1, 1'b0));
        send_beat(make_beat(24'h55AA55, 24'h55AA55, 8'h7F, 1'b0, 1'b1));

        // Sender mostly busy, receiver mostly stalled; one long hold-off
        // while single-entry runs keep coming and back the block up.
        random_phase(300);
        hold_reqs++;
        for (i = 0; i < 40; i++)
            send_run(1, 1'b0);
        random_phase(310);

        // Sender mostly idle, receiver mostly ready; one full drain midway.
        tx_idle_pct = 74;
        rx_idle_pct = 9;
        random_phase(320);
        drain_results();
        random_phase(320);

        // Back to back on both sides.
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        random_phase(650);

        drain_results();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// File: nearest_palette_color_redmean.f
rtl/core/npcr_pkg.sv
rtl/core/npcr_dist.sv
rtl/core/npcr_fifo.sv
rtl/core/npcr_best.sv
rtl/core/nearest_palette_color_redmean.sv
test/nearest_palette_color_redmean_checker.sv
test/nearest_palette_color_redmean_tb.sv
